### src/mah_pkg.sv
// Shared types, register indexes, state encoding and saturation helpers for
// the modulated allpass block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mah_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEFF_W  = 16;
   localparam int NOMDLY_W = 19;
   localparam int DEPTH_W  = 16;
   localparam int STEP_W   = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;
   localparam int SINE_W   = 17;
   localparam int COEF_W   = 28;
   localparam int ACC_W    = 58;
   localparam int PROD_W   = 40;

   localparam logic [CSR_IDX_W-1:0] REG_ALLPASS_COEFF = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL_DELAY = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOD_DEPTH     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP    = 8'd3;

   typedef struct packed {
      logic signed [COEFF_W-1:0] allpass_coeff;
      logic [NOMDLY_W-1:0]       nominal_delay;
      logic [DEPTH_W-1:0]        mod_depth;
      logic [STEP_W-1:0]         phase_step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LFO, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_TAP, ST_COEF,
      ST_H1, ST_H2, ST_H3, ST_DLY, ST_GD, ST_V, ST_GV, ST_OUT
   } state_type;

   // round to nearest, ties upward, then shift right
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
      round_shift = (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) begin
         sat24 = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         sat24 = 24'sh800000;
      end else begin
         sat24 = v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### src/mah_if.sv
// Handshake channel interfaces: sample request, sample response and
// register write port. Depend on mah_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface mah_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mah_pkg::SAMPLE_W-1:0]  sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface mah_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mah_pkg::SAMPLE_W-1:0]  sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface mah_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mah_pkg::CSR_IDX_W-1:0]       index;
   logic [mah_pkg::CSR_DATA_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/mah_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mah_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### src/mah_lfo.sv
// LFO phase accumulator, sine ROM and clamped fractional delay (Q.8).
// Depends on mah_pkg. Registered steps from start to done: sine index, sine, depth product, delay.
`timescale 1ns / 1ps
`default_nettype none

module mah_lfo #(
   parameter int BUFFER_DEPTH = 2048,
   parameter int SINE_ENTRIES = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  mah_pkg::cfg_type                 cfg,
   input  wire                              start,
   output logic                             done_ff,
   output logic [$clog2(BUFFER_DEPTH)-1:0]  n_ff,
   output logic [7:0]                       t_ff
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int SW = $clog2(SINE_ENTRIES);
   localparam int DW = ((AW + 9 > 21) ? AW + 9 : 21) + 1;
   localparam int PW = mah_pkg::DEPTH_W + mah_pkg::SINE_W + 1;
   localparam logic signed [DW-1:0] D_HI = DW'((BUFFER_DEPTH - 4) * 256 - 1);
   localparam logic signed [DW-1:0] D_LO = DW'(256);

   logic signed [mah_pkg::SINE_W-1:0] rom [SINE_ENTRIES];

   // quarter-wave polynomial folded at elaboration
   for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
      localparam longint P4 = longint'(gi) * 4;
      localparam longint QD = P4 / SINE_ENTRIES;
      localparam longint RM = P4 - QD * SINE_ENTRIES;
      localparam longint X0 = (RM * 65536) / SINE_ENTRIES;
      localparam longint XQ = (QD % 2 == 1) ? 65536 - X0 : X0;
      localparam longint X2 = (XQ * XQ) >> 16;
      localparam longint PA = 5223 - ((X2 * 307) >> 16);
      localparam longint PB = 42334 - ((X2 * PA) >> 16);
      localparam longint PC = 102944 - ((X2 * PB) >> 16);
      localparam longint SM = (((XQ * PC) >> 16) + 1) >> 1;
      localparam longint SV = (QD >= 2) ? -SM : SM;
      assign rom[gi] = mah_pkg::SINE_W'(SV);
   end

   logic [31:0]                       phase_ff;
   logic [SW-1:0]                     idx_ff;
   logic signed [mah_pkg::SINE_W-1:0] sine_ff;
   logic signed [PW-1:0]              prod_ff;
   logic [2:0]                        vld_ff;
   logic [32+SW-1:0]                  idx_full;
   logic signed [63:0]                swing;
   logic signed [DW-1:0]              d_raw;
   logic signed [DW-1:0]              d_cl;

   assign idx_full = (32+SW)'(phase_ff) * (32+SW)'(SINE_ENTRIES);
   assign swing    = mah_pkg::round_shift(64'(prod_ff), 15);
   assign d_raw    = $signed(DW'(cfg.nominal_delay)) + DW'(swing);

   always_comb begin
      d_cl = d_raw;
      if (d_raw > D_HI) begin
         d_cl = D_HI;
      end else if (d_raw < D_LO) begin
         d_cl = D_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         vld_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[1:0], start};
         done_ff <= vld_ff[2];
         if (start) begin
            phase_ff <= phase_ff + 32'(cfg.phase_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff <= idx_full[32+SW-1:32];
      end
      if (vld_ff[0]) begin
         sine_ff <= rom[idx_ff];
      end
      if (vld_ff[1]) begin
         prod_ff <= $signed({1'b0, cfg.mod_depth}) * PW'(sine_ff);
      end
      if (vld_ff[2]) begin
         n_ff <= d_cl[AW+7:8];
         t_ff <= d_cl[7:0];
      end
   end

endmodule

`default_nettype wire

### src/modulated_allpass_hermite_top.sv
// LFO-modulated allpass with 4-point Hermite fractional delay: top level.
// Depends on mah_pkg, mah_if, mah_ram and mah_lfo.
//
// Usage:
//   req_ch carries one Q1.23 sample per word; rsp_ch returns one filtered
//   Q1.23 sample per accepted word, in order. csr_ch writes the registers
//   allpass_coeff (0), nominal_delay (1), mod_depth (2), phase_step (3);
//   other indexes are dropped. csr_ch is always ready; write only while idle.
//   The next item is taken only once the previous one's result is
//   registered and the block is idle again, so one item is in flight at a
//   time. The four delay taps are read one per cycle from the
//   single-read-port delay store and the Hermite cubic runs as three Horner
//   steps. The result sits in an output register: a new item is accepted
//   while it waits, and the block holds in its last step only if the
//   previous result has still not been taken. Reset clears the LFO phase,
//   write pointer and the store fill count, and sets the registers to zero
//   but nominal_delay, which resets to 256; unwritten store slots read as
//   zero, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module modulated_allpass_hermite_top #(
   parameter int BUFFER_DEPTH = 2048,
   parameter int SINE_ENTRIES = 1024
) (
   input wire         clock,
   input wire         reset,
   mah_req_if.sink    req_ch,
   mah_rsp_if.source  rsp_ch,
   mah_csr_if.sink    csr_ch
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int SMP = mah_pkg::SAMPLE_W;

   mah_pkg::cfg_type   cfg_ff;
   mah_pkg::state_type state_ff, state_in;

   logic [AW-1:0]  wp_ff;
   logic [AW:0]    fill_ff;
   logic [AW-1:0]  n_val;
   logic [7:0]     t_val;
   logic           lfo_done;
   logic           lfo_start;

   logic signed [SMP-1:0]                x_ff;
   logic signed [SMP-1:0]                y_ff [4];
   logic signed [mah_pkg::COEF_W-1:0]    c1_ff, c2_ff, c3_ff;
   logic signed [mah_pkg::ACC_W-1:0]     h_ff;
   logic signed [SMP-1:0]                dly_ff;
   logic signed [SMP-1:0]                v_ff;
   logic signed [mah_pkg::PROD_W-1:0]    p_ff;
   logic signed [SMP-1:0]                out_ff;
   logic                                 out_vld_ff;
   logic                                 rd_ok_ff;

   logic [AW:0]            tap_k;
   logic [AW:0]            tap_diff;
   logic [AW-1:0]          rd_addr;
   logic [SMP-1:0]         rd_data;
   logic signed [SMP-1:0]  tap_val;
   logic signed [8:0]      ts;
   logic                   out_free;
   logic                   wr_en;
   logic signed [SMP-1:0]  y_res;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == mah_pkg::ST_IDLE);
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.sample_out = out_ff;
   assign lfo_start = req_ch.valid && req_ch.ready;
   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign wr_en = (state_ff == mah_pkg::ST_OUT) && out_free;
   assign ts = $signed({1'b0, t_val});
   assign tap_val = rd_ok_ff ? $signed(rd_data) : '0;
   assign y_res = mah_pkg::sat24(64'(dly_ff) + mah_pkg::round_shift(64'(p_ff), 15));

   mah_lfo #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_lfo (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .start   (lfo_start),
      .done_ff (lfo_done),
      .n_ff    (n_val),
      .t_ff    (t_val)
   );

   mah_ram #(
      .WIDTH(SMP),
      .DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wp_ff),
      .wr_data    (v_ff),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // tap delay for the read issued this cycle: n-1, n, n+1, n+2
   always_comb begin
      unique case (state_ff)
         mah_pkg::ST_RD0: tap_k = {1'b0, n_val} - (AW+1)'(1);
         mah_pkg::ST_RD1: tap_k = {1'b0, n_val};
         mah_pkg::ST_RD2: tap_k = {1'b0, n_val} + (AW+1)'(1);
         default:         tap_k = {1'b0, n_val} + (AW+1)'(2);
      endcase
      tap_diff = {1'b0, wp_ff} - tap_k;
      if (tap_diff[AW]) begin
         tap_diff = tap_diff + (AW+1)'(BUFFER_DEPTH);
      end
      rd_addr = tap_diff[AW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mah_pkg::ST_IDLE: if (lfo_start) state_in = mah_pkg::ST_LFO;
         mah_pkg::ST_LFO:  if (lfo_done) state_in = mah_pkg::ST_RD0;
         mah_pkg::ST_RD0:  state_in = mah_pkg::ST_RD1;
         mah_pkg::ST_RD1:  state_in = mah_pkg::ST_RD2;
         mah_pkg::ST_RD2:  state_in = mah_pkg::ST_RD3;
         mah_pkg::ST_RD3:  state_in = mah_pkg::ST_TAP;
         mah_pkg::ST_TAP:  state_in = mah_pkg::ST_COEF;
         mah_pkg::ST_COEF: state_in = mah_pkg::ST_H1;
         mah_pkg::ST_H1:   state_in = mah_pkg::ST_H2;
         mah_pkg::ST_H2:   state_in = mah_pkg::ST_H3;
         mah_pkg::ST_H3:   state_in = mah_pkg::ST_DLY;
         mah_pkg::ST_DLY:  state_in = mah_pkg::ST_GD;
         mah_pkg::ST_GD:   state_in = mah_pkg::ST_V;
         mah_pkg::ST_V:    state_in = mah_pkg::ST_GV;
         mah_pkg::ST_GV:   state_in = mah_pkg::ST_OUT;
         mah_pkg::ST_OUT:  if (out_free) state_in = mah_pkg::ST_IDLE;
         default:          state_in = mah_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mah_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         cfg_ff.allpass_coeff <= '0;
         cfg_ff.nominal_delay <= mah_pkg::NOMDLY_W'(256);
         cfg_ff.mod_depth     <= '0;
         cfg_ff.phase_step    <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            out_vld_ff <= 1'b1;
            wp_ff <= (wp_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
            if (fill_ff != (AW+1)'(BUFFER_DEPTH)) begin
               fill_ff <= fill_ff + (AW+1)'(1);
            end
         end else if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               mah_pkg::REG_ALLPASS_COEFF:
                  cfg_ff.allpass_coeff <= csr_ch.data[mah_pkg::COEFF_W-1:0];
               mah_pkg::REG_NOMINAL_DELAY:
                  cfg_ff.nominal_delay <= csr_ch.data[mah_pkg::NOMDLY_W-1:0];
               mah_pkg::REG_MOD_DEPTH:
                  cfg_ff.mod_depth <= csr_ch.data[mah_pkg::DEPTH_W-1:0];
               mah_pkg::REG_PHASE_STEP:
                  cfg_ff.phase_step <= csr_ch.data[mah_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath; slots never written since reset read as zero
   always_ff @(posedge clock) begin
      rd_ok_ff <= ({1'b0, rd_addr} < fill_ff);
      if (lfo_start) begin
         x_ff <= req_ch.sample_in;
      end
      unique case (state_ff)
         mah_pkg::ST_RD1: y_ff[0] <= tap_val;
         mah_pkg::ST_RD2: y_ff[1] <= tap_val;
         mah_pkg::ST_RD3: y_ff[2] <= tap_val;
         mah_pkg::ST_TAP: y_ff[3] <= tap_val;
         mah_pkg::ST_COEF: begin
            c1_ff <= mah_pkg::COEF_W'(y_ff[2]) - mah_pkg::COEF_W'(y_ff[0]);
            c2_ff <= mah_pkg::COEF_W'(2) * mah_pkg::COEF_W'(y_ff[0])
                   - mah_pkg::COEF_W'(5) * mah_pkg::COEF_W'(y_ff[1])
                   + mah_pkg::COEF_W'(4) * mah_pkg::COEF_W'(y_ff[2])
                   - mah_pkg::COEF_W'(y_ff[3]);
            c3_ff <= (mah_pkg::COEF_W'(y_ff[3]) - mah_pkg::COEF_W'(y_ff[0]))
                   + mah_pkg::COEF_W'(3)
                     * (mah_pkg::COEF_W'(y_ff[1]) - mah_pkg::COEF_W'(y_ff[2]));
         end
         mah_pkg::ST_H1:
            h_ff <= mah_pkg::ACC_W'(c3_ff) * mah_pkg::ACC_W'(ts)
                  + (mah_pkg::ACC_W'(c2_ff) <<< 8);
         mah_pkg::ST_H2:
            h_ff <= h_ff * mah_pkg::ACC_W'(ts) + (mah_pkg::ACC_W'(c1_ff) <<< 16);
         mah_pkg::ST_H3:
            h_ff <= h_ff * mah_pkg::ACC_W'(ts) + (mah_pkg::ACC_W'(y_ff[1]) <<< 25);
         mah_pkg::ST_DLY:
            dly_ff <= mah_pkg::sat24(mah_pkg::round_shift(64'(h_ff), 25));
         mah_pkg::ST_GD:
            p_ff <= mah_pkg::PROD_W'(cfg_ff.allpass_coeff) * mah_pkg::PROD_W'(dly_ff);
         mah_pkg::ST_V:
            v_ff <= mah_pkg::sat24(64'(x_ff) - mah_pkg::round_shift(64'(p_ff), 15));
         mah_pkg::ST_GV:
            p_ff <= mah_pkg::PROD_W'(cfg_ff.allpass_coeff) * mah_pkg::PROD_W'(v_ff);
         mah_pkg::ST_OUT: if (out_free) out_ff <= y_res;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### src/mah_checker.sv
// Port-level checks for modulated_allpass_hermite_top, bound to the top.
// Depends on mah_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module mah_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [mah_pkg::SAMPLE_W-1:0]  sample_out
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out))
      else $error("response word dropped or changed while stalled");

   // one item in flight: no second word taken right after the first
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item is in flight");

   // a response never follows its word in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response appeared too early");

   // nothing comes out straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modulated_allpass_hermite_top mah_checker u_mah_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .sample_out (rsp_ch.sample_out)
);

`default_nettype wire

### dv/modulated_allpass_hermite_top_tb.sv
// Self-checking bench for the LFO-modulated Hermite allpass: random and directed
// samples against a cycle-free predictor. Depends on mah_pkg, mah_if and the top level.
`timescale 1ns / 1ps
`default_nettype none

module modulated_allpass_hermite_top_tb;

   localparam int STORE_DEPTH = 2048;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 24;
   localparam int SW = mah_pkg::SAMPLE_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mah_req_if req_ch();
   mah_rsp_if rsp_ch();
   mah_csr_if csr_ch();

   modulated_allpass_hermite_top uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always #10 clock = ~clock;

   // predictor state
   logic signed [SW-1:0] echo_line [STORE_DEPTH];
   logic [10:0]          echo_wr;
   logic [31:0]          lfo_acc;
   mah_pkg::cfg_type     model_cfg;

   logic [SW-1:0] pending_samples[$];
   logic [SW-1:0] expected_out[$];
   int  pushed_cnt = 0, accepted_cnt = 0, errors = 0, quiet_cycles = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   int  hold_cnt = 0;
   bit  pressure_req = 0, pressure_done = 0;
   bit  req_took = 0, csr_took = 0;

   function automatic longint lfo_sine(input logic [31:0] ph);
      longint unsigned x, x2, p, s;
      logic [1:0] quad;
      quad = ph[31:30];
      x = {ph[29:22], 8'd0};
      if (quad[0]) x = 65536 - x;
      x2 = (x * x) >> 16;
      p = 5223 - ((x2 * 307) >> 16);
      p = 42334 - ((x2 * p) >> 16);
      p = 102944 - ((x2 * p) >> 16);
      s = (((x * p) >> 16) + 1) >> 1;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint rnd_shift(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic logic [SW-1:0] filter_sample(input logic signed [SW-1:0] xin);
      longint g, d, hi, ym1, y0, y1, y2, t, c1, c2, c3, acc, dly, v, y;
      logic [10:0] n;
      g = longint'(model_cfg.allpass_coeff);
      d = longint'(model_cfg.nominal_delay) +
          rnd_shift(longint'(model_cfg.mod_depth) * lfo_sine(lfo_acc), 15);
      lfo_acc = lfo_acc + 32'(model_cfg.phase_step);
      hi = longint'(STORE_DEPTH - 4) * 256 - 1;
      if (d > hi) d = hi;
      if (d < 256) d = 256;
      n = 11'(d >>> 8);
      t = d & 255;
      ym1 = longint'(echo_line[11'(echo_wr - n + 11'd1)]);
      y0  = longint'(echo_line[11'(echo_wr - n)]);
      y1  = longint'(echo_line[11'(echo_wr - n - 11'd1)]);
      y2  = longint'(echo_line[11'(echo_wr - n - 11'd2)]);
      c1 = y1 - ym1;
      c2 = 2 * ym1 - 5 * y0 + 4 * y1 - y2;
      c3 = (y2 - ym1) + 3 * (y0 - y1);
      acc = c3 * t * t * t + c2 * t * t * 256 + c1 * t * 65536 + y0 * 2 * 16777216;
      dly = clip24(rnd_shift(acc, 25));
      v = clip24(longint'(xin) - rnd_shift(g * dly, 15));
      y = clip24(dly + rnd_shift(g * v, 15));
      echo_line[echo_wr] = v[SW-1:0];
      echo_wr = echo_wr + 11'd1;
      return y[SW-1:0];
   endfunction

   // sample and register handshakes, predict and check
   always @(posedge clock) begin
      req_took = req_ch.valid && req_ch.ready && !reset;
      csr_took = csr_ch.valid && csr_ch.ready && !reset;
      if (reset) begin
         foreach (echo_line[i]) echo_line[i] = '0;
         echo_wr = '0;
         lfo_acc = '0;
         model_cfg = '{allpass_coeff: '0, nominal_delay: 19'd256, mod_depth: '0,
                       phase_step: '0};
      end else begin
         if (csr_took) begin
            case (csr_ch.index)
               mah_pkg::REG_ALLPASS_COEFF:
                  model_cfg.allpass_coeff = csr_ch.data[mah_pkg::COEFF_W-1:0];
               mah_pkg::REG_NOMINAL_DELAY:
                  model_cfg.nominal_delay = csr_ch.data[mah_pkg::NOMDLY_W-1:0];
               mah_pkg::REG_MOD_DEPTH:
                  model_cfg.mod_depth     = csr_ch.data[mah_pkg::DEPTH_W-1:0];
               mah_pkg::REG_PHASE_STEP:
                  model_cfg.phase_step    = csr_ch.data[mah_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_took) begin
            expected_out.push_back(filter_sample(req_ch.sample_in));
            accepted_cnt++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_out.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time,
                        rsp_ch.sample_out);
               errors++;
            end else begin
               logic [SW-1:0] want;
               want = expected_out.pop_front();
               if (rsp_ch.sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %h, actual %h", $time,
                           want, rsp_ch.sample_out);
                  errors++;
               end
            end
         end
         if (req_took || csr_took || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // sample driver
   always @(negedge clock) begin
      logic          nv;
      logic [SW-1:0] nd;
      nv = req_ch.valid;
      nd = req_ch.sample_in;
      if (req_took) nv = 1'b0;
      if (!reset && !nv && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         nd = pending_samples.pop_front();
         nv = 1'b1;
      end
      req_ch.valid     <= nv;
      req_ch.sample_in <= nd;
   end

   // response side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (pressure_req && !pressure_done && hold_cnt == 0) begin
         hold_cnt = 300;
         pressure_done = 1;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic add_sample(input logic [SW-1:0] s);
      pending_samples.push_back(s);
      pushed_cnt++;
   endtask

   task automatic write_reg(input logic [mah_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mah_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(negedge clock); while (!csr_took);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      wait (accepted_cnt == pushed_cnt && expected_out.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_random(input int count);
      repeat (count) begin
         case ($urandom_range(9))
            0: add_sample(24'h7FFFFF);
            1: add_sample(24'h800000);
            2: add_sample(24'($urandom_range(0, 255)));
            default: add_sample(24'($urandom()));
         endcase
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: shortest delay, zero gain, extremes and alternation
      add_sample(24'h7FFFFF); add_sample(24'h800000); add_sample(24'h000000);
      add_sample(24'hFFFFFF); add_sample(24'h000001);
      for (int i = 0; i < 6; i++) add_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
      drain();

      // full positive gain, nominal below one sample gets clamped up
      write_reg(mah_pkg::REG_ALLPASS_COEFF, 24'h007FFF);
      write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'h000000);
      for (int i = 0; i < 4; i++) add_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
      drain();

      // full negative gain, longest delay clamp, deepest swing, fastest LFO
      write_reg(mah_pkg::REG_ALLPASS_COEFF, 24'hFF8000);
      write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'h07FFFF);
      write_reg(mah_pkg::REG_MOD_DEPTH, 24'h00FFFF);
      write_reg(mah_pkg::REG_PHASE_STEP, 24'hFFFFFF);
      write_reg(8'd9, 24'h123456);
      for (int i = 0; i < 5; i++) add_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
      drain();

      // fractional delay near a few samples: Hermite overshoot on steps
      write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'h000280);
      write_reg(mah_pkg::REG_MOD_DEPTH, 24'h000000);
      write_reg(mah_pkg::REG_ALLPASS_COEFF, 24'h004000);
      for (int i = 0; i < 6; i++) add_sample((i % 3 == 0) ? 24'h7FFFFF : 24'h800000);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         write_reg(mah_pkg::REG_ALLPASS_COEFF, 24'($urandom()));
         case ($urandom_range(3))
            0: write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'($urandom_range(0, 8 * 256)));
            1: write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'h07FFFF);
            default: write_reg(mah_pkg::REG_NOMINAL_DELAY, 24'($urandom()));
         endcase
         write_reg(mah_pkg::REG_MOD_DEPTH,
                   ph[0] ? 24'($urandom()) : 24'($urandom_range(0, 4096)));
         write_reg(mah_pkg::REG_PHASE_STEP,
                   ph[1] ? 24'($urandom()) : 24'($urandom_range(0, 65535)));
         if (ph == 4) pressure_req = 1;
         add_random(230);
         drain();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
src/mah_pkg.sv
src/mah_if.sv
src/mah_ram.sv
src/mah_lfo.sv
src/modulated_allpass_hermite_top.sv
src/mah_checker.sv
dv/modulated_allpass_hermite_top_tb.sv
